// ===== sv/slid_pkg.sv =====
// shared types and constants for the sorted list insert/delete block
`default_nettype none
package slid_pkg;

   localparam int ValueWidth = 32;
   localparam int CountWidth = 5;

   // operation codes
   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_DELETED   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      op_type                        operation;
      logic signed [ValueWidth-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                    status;
      logic [CountWidth-1:0]         entry_count;
      logic                          first_valid;
      logic signed [ValueWidth-1:0]  first_value;
   } rsp_type;

   // broadcast control from the top level to every cell
   typedef struct packed {
      logic                          insert_en;
      logic                          delete_en;
      logic                          descending;
      logic signed [ValueWidth-1:0]  value;
   } ctrl_type;

endpackage
`default_nettype wire

// ===== sv/slid_cell.sv =====
// one list cell: holds a single entry and shifts with its neighbors
`default_nettype none
module slid_cell (
   input  wire logic                                   clock,
   input  wire slid_pkg::ctrl_type                     ctrl,
   input  wire logic                                   occupied,
   input  wire logic                                   at_tail,
   input  wire logic signed [slid_pkg::ValueWidth-1:0] left_value,
   input  wire logic signed [slid_pkg::ValueWidth-1:0] right_value,
   input  wire logic                                   hit_before_in,
   output logic                                        hit_before_out,
   output logic signed [slid_pkg::ValueWidth-1:0]      entry_ff
);

   logic signed [slid_pkg::ValueWidth-1:0] entry_in;
   logic                                   comes_after;
   logic                                   hit;

   // placement test for insert, equality test for delete
   always_comb begin
      comes_after = ctrl.descending ? (ctrl.value < entry_ff) : (ctrl.value > entry_ff);
      if (ctrl.delete_en) begin
         hit = occupied && (entry_ff == ctrl.value);
      end else begin
         hit = occupied && !comes_after;
      end
      hit_before_out = hit_before_in || hit;
   end

   // next entry: keep, take new value, shift back or close the gap
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en) begin
         if (hit_before_in) begin
            entry_in = left_value;
         end else if (hit || at_tail) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.delete_en) begin
         if (hit_before_out) begin
            entry_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

// ===== sv/sorted_list_insert_delete.sv =====
// top level of the sorted list insert/delete block
// Keeps up to CAPACITY signed 32-bit entries in ascending or descending
// order, as csr_write_data selects when csr_write_enable is high.
// Each request transfer carries an operation (insert or delete) and a
// value; each one yields exactly one response transfer with a status,
// the entry count after the operation and the entry at the front.
// The list is a row of cells; every cell compares against the request
// in parallel and shifts one place toward or from its neighbor, so an
// item is finished in the cycle it is accepted. The response appears in
// the next cycle, and a new request is taken every cycle while the
// response side does not stall.
// While rsp_valid is high and rsp_stall is high, req_stall is raised and
// the response holds unchanged until it is taken.
// Synchronous reset empties the list, clears the response slot and
// selects ascending order; entry storage itself is not cleared.
`default_nettype none
module sorted_list_insert_delete #(
   parameter int CAPACITY = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire slid_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output slid_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_write_data
);

   localparam int CntW = $clog2(CAPACITY + 1);

   logic                                   descending_ff;
   logic [CntW-1:0]                        count_ff;
   logic [CntW-1:0]                        count_in;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   slid_pkg::status_type                   status_ff;
   slid_pkg::status_type                   status_in;
   logic                                   accept;
   logic                                   full;
   logic                                   found;
   logic [31:0]                            count_wide;
   slid_pkg::ctrl_type                     ctrl;
   logic [CAPACITY:0]                      hit_chain;
   logic signed [slid_pkg::ValueWidth-1:0] entries [CAPACITY];

   // request handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CntW'(CAPACITY));

   // control broadcast to the cells
   always_comb begin
      ctrl.insert_en  = accept && (req_data.operation == slid_pkg::OP_INSERT) && !full;
      ctrl.delete_en  = accept && (req_data.operation == slid_pkg::OP_DELETE);
      ctrl.descending = descending_ff;
      ctrl.value      = req_data.value;
   end

   // cell row
   assign hit_chain[0] = 1'b0;
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [slid_pkg::ValueWidth-1:0] left_v;
      logic signed [slid_pkg::ValueWidth-1:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = req_data.value;
      end else begin : g_mid_l
         assign left_v = entries[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = entries[i];
      end else begin : g_mid_r
         assign right_v = entries[i+1];
      end
      slid_cell u_cell (
         .clock          (clock),
         .ctrl           (ctrl),
         .occupied       (CntW'(i) < count_ff),
         .at_tail        (CntW'(i) == count_ff),
         .left_value     (left_v),
         .right_value    (right_v),
         .hit_before_in  (hit_chain[i]),
         .hit_before_out (hit_chain[i+1]),
         .entry_ff       (entries[i])
      );
   end
   assign found = hit_chain[CAPACITY];

   // count, status and response slot
   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_data.operation == slid_pkg::OP_INSERT) begin
            if (full) begin
               status_in = slid_pkg::ST_FULL;
            end else begin
               status_in = slid_pkg::ST_INSERTED;
               count_in  = count_ff + CntW'(1);
            end
         end else begin
            if (found) begin
               status_in = slid_pkg::ST_DELETED;
               count_in  = count_ff - CntW'(1);
            end else begin
               status_in = slid_pkg::ST_NOT_FOUND;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         descending_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         status_ff     <= slid_pkg::ST_INSERTED;
      end else begin
         if (csr_write_enable) begin
            descending_ff <= csr_write_data;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   // response payload comes straight from registers
   assign count_wide = 32'(count_ff);
   assign rsp_valid  = rsp_valid_ff;
   always_comb begin
      rsp_data.status      = status_ff;
      rsp_data.entry_count = count_wide[slid_pkg::CountWidth-1:0];
      rsp_data.first_valid = (count_ff != '0);
      rsp_data.first_value = (count_ff != '0) ? entries[0] : '0;
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request without response");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert_en |=> (count_ff == $past(count_ff) + CntW'(1)))
      else $error("insert did not grow the list");

   a_status_count: assert property (@(posedge clock) disable iff (reset)
      (accept && ctrl.delete_en && !found) |=>
         (status_ff == slid_pkg::ST_NOT_FOUND && $stable(count_ff)))
      else $error("failed delete changed the count");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the sorted list insert/delete block: directed table, random list traffic
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Capacity = 16;
   localparam logic signed [slid_pkg::ValueWidth-1:0] ValMin = 32'sh8000_0000;
   localparam logic signed [slid_pkg::ValueWidth-1:0] ValMax = 32'sh7fff_ffff;
   localparam int DirRows = 24;
   localparam int RandPhases = 8;
   localparam int PhaseItems = 50;

   // one row of the directed table; want is used only where typed is set
   typedef struct packed {
      slid_pkg::op_type                       op;
      logic signed [slid_pkg::ValueWidth-1:0] value;
      logic                                   typed;
      slid_pkg::rsp_type                      want;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   slid_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   slid_pkg::rsp_type rsp_data;
   logic              csr_write_enable;
   logic              csr_write_data;

   // shadow copy of the list and its order setting
   logic signed [slid_pkg::ValueWidth-1:0] shadow_list [Capacity];
   int      shadow_len = 0;
   logic    shadow_desc = 1'b0;

   slid_pkg::rsp_type list_reports_q [$];
   slid_pkg::rsp_type want_rsp;
   int      fail_count = 0;
   int      reports_seen = 0;
   int      requests_sent = 0;
   int      order_writes = 0;
   int      burst_left = 0;
   int      status_seen [4] = '{0, 0, 0, 0};

   // directed rows: empty list, only entry, extremes, duplicates, absent value, full list
   dir_row_type dir_table [DirRows] = '{
      '{slid_pkg::OP_DELETE, 32'sd0, 1'b1, '{slid_pkg::ST_NOT_FOUND, 5'd0, 1'b0, 32'sd0}},
      '{slid_pkg::OP_INSERT, 32'sd7, 1'b1, '{slid_pkg::ST_INSERTED, 5'd1, 1'b1, 32'sd7}},
      '{slid_pkg::OP_DELETE, 32'sd7, 1'b1, '{slid_pkg::ST_DELETED, 5'd0, 1'b0, 32'sd0}},
      '{slid_pkg::OP_INSERT, ValMin, 1'b1, '{slid_pkg::ST_INSERTED, 5'd1, 1'b1, ValMin}},
      '{slid_pkg::OP_INSERT, ValMax, 1'b1, '{slid_pkg::ST_INSERTED, 5'd2, 1'b1, ValMin}},
      '{slid_pkg::OP_INSERT, 32'sd0,         1'b0, '0},
      '{slid_pkg::OP_INSERT, -32'sd1,        1'b0, '0},
      '{slid_pkg::OP_INSERT, 32'sd0,         1'b0, '0},
      '{slid_pkg::OP_DELETE, 32'sd12345,     1'b0, '0},
      '{slid_pkg::OP_DELETE, ValMin,         1'b0, '0},
      '{slid_pkg::OP_INSERT, 32'sh5555_5555, 1'b0, '0},
      '{slid_pkg::OP_INSERT, 32'shaaaa_aaaa, 1'b0, '0},
      '{slid_pkg::OP_INSERT, -32'sd1,        1'b0, '0},
      '{slid_pkg::OP_INSERT, 32'sd1,         1'b0, '0},
      '{slid_pkg::OP_INSERT, 32'sd0,         1'b0, '0},
      '{slid_pkg::OP_INSERT, 32'sd100,       1'b0, '0},
      '{slid_pkg::OP_INSERT, -32'sd100,      1'b0, '0},
      '{slid_pkg::OP_INSERT, ValMax,         1'b0, '0},
      '{slid_pkg::OP_INSERT, ValMin,         1'b0, '0},
      '{slid_pkg::OP_INSERT, 32'sd2,         1'b0, '0},
      '{slid_pkg::OP_INSERT, -32'sd2,        1'b0, '0},
      '{slid_pkg::OP_INSERT, 32'sd3,         1'b0, '0},
      '{slid_pkg::OP_INSERT, 32'sd9, 1'b1, '{slid_pkg::ST_FULL, 5'd16, 1'b1, ValMin}},
      '{slid_pkg::OP_DELETE, ValMax,         1'b0, '0}
   };

   sorted_list_insert_delete #(
      .CAPACITY(Capacity)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // true when v must sit strictly behind e in the current order
   function automatic bit follows_in_order(logic signed [slid_pkg::ValueWidth-1:0] v,
                                           logic signed [slid_pkg::ValueWidth-1:0] e);
      return shadow_desc ? (v < e) : (v > e);
   endfunction

   // apply one operation to the shadow list and return the report it yields
   function automatic slid_pkg::rsp_type apply_to_list(slid_pkg::req_type item);
      slid_pkg::rsp_type report;
      int slot;
      slot = shadow_len;
      if (item.operation == slid_pkg::OP_INSERT) begin
         if (shadow_len >= Capacity) begin
            report.status = slid_pkg::ST_FULL;
         end else begin
            for (int i = shadow_len - 1; i >= 0; i--)
               if (!follows_in_order($signed(item.value), shadow_list[i]))
                  slot = i;
            for (int i = shadow_len; i > slot; i--)
               shadow_list[i] = shadow_list[i-1];
            shadow_list[slot] = item.value;
            shadow_len++;
            report.status = slid_pkg::ST_INSERTED;
         end
      end else begin
         for (int i = shadow_len - 1; i >= 0; i--)
            if (shadow_list[i] == item.value)
               slot = i;
         if (slot < shadow_len) begin
            for (int i = slot; i < shadow_len - 1; i++)
               shadow_list[i] = shadow_list[i+1];
            shadow_len--;
            report.status = slid_pkg::ST_DELETED;
         end else begin
            report.status = slid_pkg::ST_NOT_FOUND;
         end
      end
      report.entry_count = slid_pkg::CountWidth'(shadow_len);
      report.first_valid = (shadow_len > 0);
      report.first_value = (shadow_len > 0) ? shadow_list[0] : '0;
      return report;
   endfunction

   // random operation, often on values already in the list (deletes more so than inserts)
   function automatic slid_pkg::req_type pick_list_op(bit filling);
      slid_pkg::req_type item;
      int roll;
      int sub;
      roll = $urandom_range(0, 99);
      sub = $urandom_range(0, 9);
      item.operation = ($urandom_range(0, 99) < (filling ? 70 : 30)) ?
                       slid_pkg::OP_INSERT : slid_pkg::OP_DELETE;
      if (shadow_len > 0 && roll < ((item.operation == slid_pkg::OP_DELETE) ? 65 : 25)) begin
         item.value = shadow_list[$urandom_range(0, shadow_len - 1)];
      end else if (sub < 2) begin
         case ($urandom_range(0, 3))
            0: item.value = ValMin;
            1: item.value = ValMax;
            2: item.value = 32'sd0;
            default: item.value = -32'sd1;
         endcase
      end else if (sub < 5) begin
         item.value = 32'($urandom_range(0, 16)) - 32'd8;
      end else begin
         item.value = $urandom;
      end
      return item;
   endfunction

   // offer one request in the current burst and record its report on transfer
   task automatic send_item(slid_pkg::req_type item, bit typed, slid_pkg::rsp_type typed_rsp);
      slid_pkg::rsp_type predicted;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_to_list(item);
      list_reports_q.push_back(typed ? typed_rsp : predicted);
      requests_sent++;
   endtask

   // change the order bit once the block has drained
   task automatic set_order(bit descending);
      @(negedge clock);
      req_valid <= 1'b0;
      while (list_reports_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= descending;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_desc = descending;
      order_writes++;
      burst_left = 0;
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         reports_seen++;
         status_seen[rsp_data.status]++;
         if (list_reports_q.size() == 0) begin
            $error("response transfer with nothing expected");
            fail_count++;
         end else begin
            want_rsp = list_reports_q.pop_front();
            if (rsp_data.status !== want_rsp.status) begin
               $error("status: expected %0d, got %0d", want_rsp.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.entry_count !== want_rsp.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      want_rsp.entry_count, rsp_data.entry_count);
               fail_count++;
            end
            if (rsp_data.first_valid !== want_rsp.first_valid) begin
               $error("first_valid: expected %0d, got %0d",
                      want_rsp.first_valid, rsp_data.first_valid);
               fail_count++;
            end
            if (rsp_data.first_value !== want_rsp.first_value) begin
               $error("first_value: expected %0d, got %0d",
                      want_rsp.first_value, rsp_data.first_value);
               fail_count++;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off to back up the input
   initial begin
      int mode;
      int mode_left;
      bit long_done;
      mode = 0;
      mode_left = 0;
      long_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_done && reports_seen >= 120) begin
            rsp_stall <= 1'b1;
            repeat (80) @(negedge clock);
            long_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // run limit
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // stimulus
   initial begin
      bit order_plan [RandPhases];
      bit filling;
      int n;
      int drain;
      order_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, ascending order
      set_order(1'b0);
      for (int r = 0; r < DirRows; r++)
         send_item('{dir_table[r].op, dir_table[r].value}, dir_table[r].typed,
                   dir_table[r].want);

      // random phases; the order flips while entries are still stored
      n = 0;
      for (int p = 0; p < RandPhases; p++) begin
         set_order(order_plan[p]);
         for (int k = 0; k < PhaseItems; k++) begin
            filling = ((n / 20) % 2) == 0;
            send_item(pick_list_op(filling), 1'b0, '0);
            n++;
         end
      end

      // drain and finish
      @(negedge clock);
      req_valid <= 1'b0;
      for (drain = 0; drain < 2000 && list_reports_q.size() != 0; drain++)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (list_reports_q.size() != 0) begin
         $error("%0d responses never arrived", list_reports_q.size());
         fail_count++;
      end
      $display("%0d requests, %0d responses checked, order bit written %0d times",
               requests_sent, reports_seen, order_writes);
      $display("statuses: inserted %0d, full %0d, deleted %0d, not found %0d",
               status_seen[slid_pkg::ST_INSERTED], status_seen[slid_pkg::ST_FULL],
               status_seen[slid_pkg::ST_DELETED], status_seen[slid_pkg::ST_NOT_FOUND]);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
